@@ rtl/lef_pkg.sv @@
package lef_pkg;

  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;

  localparam int PIX_W      = 8;
  localparam int SIZE_W     = 10;
  localparam int THR_W      = 12;
  localparam int RESP_W     = 13;
  localparam int CLASS_W    = 2;
  localparam int IDX_W      = 2;
  localparam int CFG_DATA_W = 12;
  localparam int ROWS_KEPT  = 5;
  localparam int LANES      = 5;
  localparam int SLOT_W     = 3;

  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;

  localparam logic [SIZE_W-1:0] RST_IMAGE_WIDTH    = 10'd481;
  localparam logic [SIZE_W-1:0] RST_IMAGE_HEIGHT   = 10'd321;
  localparam logic [THR_W-1:0]  RST_EDGE_THRESHOLD = 12'd0;

  localparam logic [CLASS_W-1:0] CLASS_LOW  = 2'd0;
  localparam logic [CLASS_W-1:0] CLASS_MID  = 2'd1;
  localparam logic [CLASS_W-1:0] CLASS_HIGH = 2'd2;

  // floor(x / 3) for x <= 765 as (x * 683) >> 11
  localparam logic [9:0] DIV3_MUL = 10'd683;

  typedef logic [PIX_W-1:0]  pix_t;
  typedef pix_t [LANES-1:0]  column_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef slot_t [LANES-1:0] slot_vec_t;

  typedef struct packed {
    logic valid;
    logic row_start;
    logic last;
  } step_t;

  function automatic slot_t slot_add(input slot_t s, input logic signed [2:0] e);
    logic [3:0] t;
    t = {1'b0, s} + 4'd5 + {e[2], e};
    if (t >= 4'd10) begin
      t = t - 4'd10;
    end else if (t >= 4'd5) begin
      t = t - 4'd5;
    end
    return t[2:0];
  endfunction

  function automatic pix_t gray_of(input pix_t r, input pix_t g, input pix_t b);
    logic [9:0]  sum;
    logic [19:0] prod;
    sum  = 10'(r) + 10'(g) + 10'(b);
    prod = 20'(sum) * 20'(DIV3_MUL);
    return prod[18:11];
  endfunction

endpackage

@@ rtl/lef_pixel_if.sv @@
interface lef_pixel_if;
  logic                   valid;
  logic                   ready;
  logic                   drain;
  logic [lef_pkg::PIX_W-1:0] red;
  logic [lef_pkg::PIX_W-1:0] green;
  logic [lef_pkg::PIX_W-1:0] blue;
  modport source(output valid, drain, red, green, blue, input ready);
  modport sink(input valid, drain, red, green, blue, output ready);
endinterface

@@ rtl/lef_result_if.sv @@
interface lef_result_if;
  logic                             valid;
  logic                             ready;
  logic signed [lef_pkg::RESP_W-1:0] response;
  logic [lef_pkg::CLASS_W-1:0]      edge_class;
  logic                             frame_last;
  modport source(output valid, response, edge_class, frame_last, input ready);
  modport sink(input valid, response, edge_class, frame_last, output ready);
endinterface

@@ rtl/lef_cfg_if.sv @@
interface lef_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lef_pkg::IDX_W-1:0]       index;
  logic [lef_pkg::CFG_DATA_W-1:0]  data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ rtl/lef_line_store.sv @@
module lef_line_store #(
  parameter int MAX_WIDTH = lef_pkg::DEF_MAX_WIDTH
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic                        wr_en,
  input  lef_pkg::slot_t              wr_slot,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_col,
  input  lef_pkg::pix_t               wr_data,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_col,
  input  lef_pkg::slot_vec_t          rd_slots,
  output lef_pkg::column_t            col_data,
  output lef_pkg::column_t            edge0,
  output lef_pkg::column_t            edge1
);
  localparam int CW = $clog2(MAX_WIDTH);

  lef_pkg::pix_t      slot_val [lef_pkg::ROWS_KEPT];
  lef_pkg::pix_t      e0_val   [lef_pkg::ROWS_KEPT];
  lef_pkg::pix_t      e1_val   [lef_pkg::ROWS_KEPT];
  lef_pkg::pix_t      wd_q;
  lef_pkg::slot_vec_t rd_slots_q;

  always_ff @(posedge clk) begin
    if (en) begin
      wd_q       <= wr_data;
      rd_slots_q <= rd_slots;
    end
  end

  for (genvar k = 0; k < lef_pkg::ROWS_KEPT; k++) begin : g_slot
    lef_pkg::pix_t mem [MAX_WIDTH];
    lef_pkg::pix_t q;
    lef_pkg::pix_t cache0;
    lef_pkg::pix_t cache1;
    lef_pkg::pix_t c0_q;
    lef_pkg::pix_t c1_q;
    logic          hit_q;
    logic          wr_here;

    assign wr_here = wr_en && (wr_slot == lef_pkg::SLOT_W'(k));

    always_ff @(posedge clk) begin
      if (wr_here) begin
        mem[wr_col] <= wr_data;
      end
      if (wr_here && wr_col == CW'(0)) begin
        cache0 <= wr_data;
      end
      if (wr_here && wr_col == CW'(1)) begin
        cache1 <= wr_data;
      end
      if (en) begin
        q     <= mem[rd_col];
        hit_q <= wr_here && (wr_col == rd_col);
        c0_q  <= cache0;
        c1_q  <= cache1;
      end
    end

    assign slot_val[k] = hit_q ? wd_q : q;
    assign e0_val[k]   = c0_q;
    assign e1_val[k]   = c1_q;
  end

  always_comb begin
    for (int l = 0; l < lef_pkg::LANES; l++) begin
      col_data[l] = slot_val[rd_slots_q[l]];
      edge0[l]    = e0_val[rd_slots_q[l]];
      edge1[l]    = e1_val[rd_slots_q[l]];
    end
  end

endmodule

@@ rtl/lef_filter.sv @@
module lef_filter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  lef_pkg::step_t                    step,
  input  lef_pkg::column_t                  col_data,
  input  lef_pkg::column_t                  edge0,
  input  lef_pkg::column_t                  edge1,
  input  logic [lef_pkg::THR_W-1:0]         threshold,
  output logic                              valid,
  output logic signed [lef_pkg::RESP_W-1:0] response,
  output logic [lef_pkg::CLASS_W-1:0]       edge_class,
  output logic                              frame_last
);
  lef_pkg::column_t win [5];
  logic        s2_valid, s2_last;
  logic        s3_valid, s3_last;
  logic [11:0] pos;
  logic [9:0]  n2;
  logic [10:0] n1;
  logic signed [13:0] r14, thr14;
  logic [lef_pkg::CLASS_W-1:0] cls;

  always_ff @(posedge clk) begin
    if (en && step.valid) begin
      if (step.row_start) begin
        win[0] <= edge0;
        win[1] <= edge0;
        win[2] <= edge0;
        win[3] <= edge1;
      end else begin
        win[0] <= win[1];
        win[1] <= win[2];
        win[2] <= win[3];
        win[3] <= win[4];
      end
      win[4] <= col_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      valid    <= 1'b0;
    end else if (en) begin
      s2_valid <= step.valid;
      s3_valid <= s2_valid;
      valid    <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_last <= step.last;
      s3_last <= s2_last;
      pos     <= {win[2][2], 4'b0};
      n2      <= 10'(win[2][1]) + 10'(win[2][3]) + 10'(win[1][2]) + 10'(win[3][2]);
      n1      <= 11'(win[2][0]) + 11'(win[2][4]) + 11'(win[0][2]) + 11'(win[4][2])
               + 11'(win[1][1]) + 11'(win[1][3]) + 11'(win[3][1]) + 11'(win[3][3]);
      response   <= r14[lef_pkg::RESP_W-1:0];
      edge_class <= cls;
      frame_last <= s3_last;
    end
  end

  always_comb begin
    r14   = $signed({2'b0, pos}) - $signed({3'b0, n2, 1'b0}) - $signed({3'b0, n1});
    thr14 = $signed({2'b0, threshold});
    if (r14 <= -thr14) begin
      cls = lef_pkg::CLASS_LOW;
    end else if (r14 >= thr14) begin
      cls = lef_pkg::CLASS_HIGH;
    end else begin
      cls = lef_pkg::CLASS_MID;
    end
  end

endmodule

@@ rtl/log_edge_filter_stream.sv @@
// Streaming 5x5 Laplacian-of-Gaussian edge filter.
// pixel: raster-order RGB requests; drain = 1 carries no pixel and only pushes
//   out results still pending after the frame's last pixel.
// result: one filter response per pixel position, in raster order, with a
//   three-way class against edge_threshold and frame_last on the final one.
// cfg: register writes (0 width, 1 height, 2 threshold), always ready; write
//   only while idle. A size write restarts the frame.
// Throughput is one request per cycle while results are taken. A result
// passes line-store read, window shift, partial sums, and final sum and class
// in the output register, after the request completing its 5x5 neighborhood.
// The five most recent rows sit in five row memories read at one shared column
// address; one new window column is read per result.
// Reset restores width 481, height 321, threshold 0 and an empty frame; the
// line memories are not cleared and need no clearing pass.
// While the output register holds a result that is not taken, the whole
// pipeline holds and pixel.ready is low.
module log_edge_filter_stream #(
  parameter int MAX_WIDTH  = lef_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = lef_pkg::DEF_MAX_HEIGHT
) (
  input logic          clk,
  input logic          rst,
  lef_pixel_if.sink    pixel,
  lef_result_if.source result,
  lef_cfg_if.sink      cfg
);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int WCMP = (CW + 1 > lef_pkg::SIZE_W) ? CW + 1 : lef_pkg::SIZE_W;
  localparam int HCMP = (RW + 1 > lef_pkg::SIZE_W) ? RW + 1 : lef_pkg::SIZE_W;

  logic [lef_pkg::SIZE_W-1:0] image_width, image_height;
  logic [lef_pkg::THR_W-1:0]  edge_threshold;
  logic [CW-1:0]  in_col, out_col;
  logic [RW-1:0]  in_row, out_row;
  lef_pkg::slot_t in_slot, out_slot;
  logic           frame_done;

  logic [CW-1:0]  in_col_next, out_col_next, oc0;
  logic [RW-1:0]  in_row_next, out_row_next, or0;
  lef_pkg::slot_t in_slot_next, out_slot_next, os0;
  logic           frame_done_next;

  logic [WCMP-1:0] w_ext;
  logic [HCMP-1:0] h_ext;
  logic [CW:0]     w, ic1, nc, oc1;
  logic [RW:0]     h, ir1, nr, rows_below;
  logic            en, accept, is_pix, rdy, emit, last;
  logic [CW-1:0]   rd_col;
  lef_pkg::slot_vec_t rd_slots;
  lef_pkg::step_t  s1_step;
  lef_pkg::column_t col_data, edge0, edge1;
  logic            out_valid;
  logic signed [2:0] e;

  always_comb begin
    w_ext = WCMP'(image_width);
    if (w_ext < WCMP'(3)) begin
      w = (CW + 1)'(3);
    end else if (w_ext > WCMP'(MAX_WIDTH)) begin
      w = (CW + 1)'(MAX_WIDTH);
    end else begin
      w = (CW + 1)'(w_ext);
    end
    h_ext = HCMP'(image_height);
    if (h_ext < HCMP'(3)) begin
      h = (RW + 1)'(3);
    end else if (h_ext > HCMP'(MAX_HEIGHT)) begin
      h = (RW + 1)'(MAX_HEIGHT);
    end else begin
      h = (RW + 1)'(h_ext);
    end
  end

  assign en          = !out_valid || result.ready;
  assign pixel.ready = en;
  assign accept      = pixel.valid && en;
  assign is_pix      = accept && !pixel.drain;
  assign cfg.ready   = 1'b1;

  always_comb begin
    frame_done_next = frame_done;
    or0 = out_row;
    oc0 = out_col;
    os0 = out_slot;
    if (is_pix && frame_done) begin
      or0 = '0;
      oc0 = '0;
      os0 = '0;
      frame_done_next = 1'b0;
    end

    in_col_next  = in_col;
    in_row_next  = in_row;
    in_slot_next = in_slot;
    ic1 = {1'b0, in_col} + (CW + 1)'(1);
    ir1 = {1'b0, in_row} + (RW + 1)'(1);
    if (is_pix) begin
      if (ic1 >= w) begin
        in_col_next = '0;
        if (ir1 >= h) begin
          in_row_next     = '0;
          in_slot_next    = '0;
          frame_done_next = 1'b1;
        end else begin
          in_row_next  = ir1[RW-1:0];
          in_slot_next = (in_slot == lef_pkg::slot_t'(lef_pkg::ROWS_KEPT - 1)) ?
                         '0 : in_slot + 1'b1;
        end
      end else begin
        in_col_next = ic1[CW-1:0];
      end
    end

    nr = {1'b0, or0} + (RW + 1)'(2);
    if (nr > h - 1'b1) begin
      nr = h - 1'b1;
    end
    nc = {1'b0, oc0} + (CW + 1)'(2);
    if (nc > w - 1'b1) begin
      nc = w - 1'b1;
    end
    rdy = frame_done_next || (nr < {1'b0, in_row_next}) ||
          ((nr == {1'b0, in_row_next}) && (nc < {1'b0, in_col_next}));
    emit   = accept && rdy;
    last   = ({1'b0, or0} == h - 1'b1) && ({1'b0, oc0} == w - 1'b1);
    rd_col = nc[CW-1:0];

    out_row_next  = or0;
    out_col_next  = oc0;
    out_slot_next = os0;
    oc1 = {1'b0, oc0} + (CW + 1)'(1);
    if (emit) begin
      if (last) begin
        out_row_next    = '0;
        out_col_next    = '0;
        out_slot_next   = '0;
        frame_done_next = 1'b0;
      end else if (oc1 >= w) begin
        out_col_next  = '0;
        out_row_next  = or0 + 1'b1;
        out_slot_next = (os0 == lef_pkg::slot_t'(lef_pkg::ROWS_KEPT - 1)) ?
                        '0 : os0 + 1'b1;
      end else begin
        out_col_next = oc1[CW-1:0];
      end
    end

    // rows beyond the frame edges fold back onto the edge row
    rows_below = h - 1'b1 - {1'b0, or0};
    for (int l = 0; l < lef_pkg::LANES; l++) begin
      e = 3'(l) - 3'd2;
      if (l < 2) begin
        if ({1'b0, or0} < (RW + 1)'(2 - l)) begin
          e = 3'd0 - {1'b0, or0[1:0]};
        end
      end else if (rows_below < (RW + 1)'(l - 2)) begin
        e = {1'b0, rows_below[1:0]};
      end
      rd_slots[l] = lef_pkg::slot_add(os0, e);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= lef_pkg::RST_IMAGE_WIDTH;
      image_height   <= lef_pkg::RST_IMAGE_HEIGHT;
      edge_threshold <= lef_pkg::RST_EDGE_THRESHOLD;
      in_col     <= '0;
      in_row     <= '0;
      in_slot    <= '0;
      out_col    <= '0;
      out_row    <= '0;
      out_slot   <= '0;
      frame_done <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        lef_pkg::REG_IMAGE_WIDTH, lef_pkg::REG_IMAGE_HEIGHT: begin
          if (cfg.index == lef_pkg::REG_IMAGE_WIDTH) begin
            image_width <= cfg.data[lef_pkg::SIZE_W-1:0];
          end else begin
            image_height <= cfg.data[lef_pkg::SIZE_W-1:0];
          end
          in_col     <= '0;
          in_row     <= '0;
          in_slot    <= '0;
          out_col    <= '0;
          out_row    <= '0;
          out_slot   <= '0;
          frame_done <= 1'b0;
        end
        lef_pkg::REG_EDGE_THRESHOLD: begin
          edge_threshold <= cfg.data;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      in_col     <= in_col_next;
      in_row     <= in_row_next;
      in_slot    <= in_slot_next;
      out_col    <= out_col_next;
      out_row    <= out_row_next;
      out_slot   <= out_slot_next;
      frame_done <= frame_done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_step <= '0;
    end else if (en) begin
      s1_step.valid     <= emit;
      s1_step.row_start <= (oc0 == '0);
      s1_step.last      <= last;
    end
  end

  lef_line_store #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_store (
    .clk     (clk),
    .en      (en),
    .wr_en   (is_pix),
    .wr_slot (in_slot),
    .wr_col  (in_col),
    .wr_data (lef_pkg::gray_of(pixel.red, pixel.green, pixel.blue)),
    .rd_col  (rd_col),
    .rd_slots(rd_slots),
    .col_data(col_data),
    .edge0   (edge0),
    .edge1   (edge1)
  );

  lef_filter u_filter (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .step      (s1_step),
    .col_data  (col_data),
    .edge0     (edge0),
    .edge1     (edge1),
    .threshold (edge_threshold),
    .valid     (out_valid),
    .response  (result.response),
    .edge_class(result.edge_class),
    .frame_last(result.frame_last)
  );

  assign result.valid = out_valid;

endmodule

@@ test/lef_filter_checker.sv @@
`timescale 1ns / 100ps

module lef_filter_checker (
  input  logic  clk,
  input  logic  rst,
  lef_pixel_if  pixel,
  lef_result_if result,
  lef_cfg_if    cfg,
  output int    fails,
  output int    outstanding
);
  import lef_pkg::*;

  typedef struct {
    logic signed [RESP_W-1:0] response;
    logic [CLASS_W-1:0]       edge_class;
    logic                     frame_last;
  } filt_res_t;

  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;
  logic [THR_W-1:0]  thr_reg;
  logic [PIX_W-1:0]  gray_rows[ROWS_KEPT][DEF_MAX_WIDTH];
  int unsigned       in_r, in_c, out_r, out_c;
  bit                all_in;
  filt_res_t         expected_q[$];
  int                fail_cnt;

  function automatic int unsigned used_size(logic [SIZE_W-1:0] v, int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int tap(int dr, int dc);
    int a, b;
    a = dr < 0 ? -dr : dr;
    b = dc < 0 ? -dc : dc;
    if (a + b == 0) return 16;
    if (a + b == 1) return -2;
    if (a + b == 2 && a < 2 && b < 2) return -1;
    if (a + b == 2) return -1;
    return 0;
  endfunction

  function automatic int clip(int v, int last);
    if (v < 0) return 0;
    if (v > last) return last;
    return v;
  endfunction

  task automatic report(string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    fail_cnt++;
  endtask

  task automatic predict_step(logic drain, logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                              logic [PIX_W-1:0] b);
    int unsigned w, h, nr, nc;
    bit          rdy;
    int          acc, th, rr, cc;
    logic [9:0]  sum;
    filt_res_t   e;
    w = used_size(width_reg, DEF_MAX_WIDTH);
    h = used_size(height_reg, DEF_MAX_HEIGHT);
    if (!drain) begin
      sum = 10'(r) + 10'(g) + 10'(b);
      if (all_in) begin
        out_r = 0;
        out_c = 0;
        all_in = 0;
      end
      gray_rows[in_r % ROWS_KEPT][in_c] = PIX_W'(sum / 3);
      in_c++;
      if (in_c >= w) begin
        in_c = 0;
        in_r++;
        if (in_r >= h) begin
          in_r = 0;
          all_in = 1;
        end
      end
    end
    if (all_in) begin
      rdy = 1;
    end else begin
      nr = out_r + 2 > h - 1 ? h - 1 : out_r + 2;
      nc = out_c + 2 > w - 1 ? w - 1 : out_c + 2;
      rdy = nr * w + nc < in_r * w + in_c;
    end
    if (!rdy) return;
    acc = 0;
    for (int dr = -2; dr <= 2; dr++) begin
      rr = clip(int'(out_r) + dr, h - 1);
      for (int dc = -2; dc <= 2; dc++) begin
        cc = clip(int'(out_c) + dc, w - 1);
        acc += tap(dr, dc) * int'(gray_rows[rr % ROWS_KEPT][cc]);
      end
    end
    th = int'(thr_reg);
    e.response = RESP_W'(acc);
    if (acc <= -th) e.edge_class = CLASS_LOW;
    else if (acc >= th) e.edge_class = CLASS_HIGH;
    else e.edge_class = CLASS_MID;
    e.frame_last = (out_r == h - 1 && out_c == w - 1);
    expected_q.push_back(e);
    if (e.frame_last) begin
      out_r = 0;
      out_c = 0;
      all_in = 0;
    end else begin
      out_c++;
      if (out_c >= w) begin
        out_c = 0;
        out_r++;
      end
    end
  endtask

  initial begin
    fail_cnt = 0;
    for (int i = 0; i < ROWS_KEPT; i++)
      for (int j = 0; j < DEF_MAX_WIDTH; j++) gray_rows[i][j] = '0;
  end

  always @(posedge clk) begin
    filt_res_t e;
    if (rst) begin
      width_reg  = RST_IMAGE_WIDTH;
      height_reg = RST_IMAGE_HEIGHT;
      thr_reg    = RST_EDGE_THRESHOLD;
      in_r = 0; in_c = 0; out_r = 0; out_c = 0; all_in = 0;
      expected_q.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (expected_q.size() == 0) begin
          report($sformatf("unexpected result %0d", result.response));
        end else begin
          e = expected_q.pop_front();
          if (result.response !== e.response)
            report($sformatf("response %0d, want %0d", result.response, e.response));
          if (result.edge_class !== e.edge_class)
            report($sformatf("edge_class %0d, want %0d", result.edge_class, e.edge_class));
          if (result.frame_last !== e.frame_last)
            report($sformatf("frame_last %0b, want %0b", result.frame_last, e.frame_last));
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_IMAGE_WIDTH: begin
            width_reg = cfg.data[SIZE_W-1:0];
            in_r = 0; in_c = 0; out_r = 0; out_c = 0; all_in = 0;
          end
          REG_IMAGE_HEIGHT: begin
            height_reg = cfg.data[SIZE_W-1:0];
            in_r = 0; in_c = 0; out_r = 0; out_c = 0; all_in = 0;
          end
          REG_EDGE_THRESHOLD: thr_reg = cfg.data[THR_W-1:0];
          default: ;
        endcase
      end
      if (pixel.valid && pixel.ready)
        predict_step(pixel.drain, pixel.red, pixel.green, pixel.blue);
    end
    outstanding <= expected_q.size();
    fails <= fail_cnt;
  end

endmodule

@@ test/tb_log_edge_filter_stream.sv @@
`timescale 1ns / 100ps

module tb_log_edge_filter_stream;
  import lef_pkg::*;

  localparam int CYCLE_LIMIT = 600000;

  logic clk;
  logic rst;
  int   fails;
  int   outstanding;
  int   cycles;
  int   burst_left;
  int   stall_left;
  int   stall_mode;
  int   random_sent;

  lef_pixel_if  pix_if();
  lef_result_if res_if();
  lef_cfg_if    cfg_if();

  log_edge_filter_stream dut (
    .clk(clk), .rst(rst), .pixel(pix_if), .result(res_if), .cfg(cfg_if)
  );

  lef_filter_checker u_checker (
    .clk(clk), .rst(rst), .pixel(pix_if), .result(res_if), .cfg(cfg_if),
    .fails(fails), .outstanding(outstanding)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_log_edge_filter_stream failed");
      $finish;
    end
  end

  // receiver stall pattern: modes change every so often
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(20, 120);
      stall_mode = $urandom_range(0, 3);
    end
    stall_left--;
    case (stall_mode)
      0: res_if.ready = 1'b1;
      1: res_if.ready = $urandom_range(0, 3) != 0;
      2: res_if.ready = $urandom_range(0, 9) < 3;
      default: res_if.ready = (cycles % 16) < 10;
    endcase
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic send_req(logic d, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        pix_if.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    pix_if.valid = 1'b1;
    pix_if.drain = d;
    pix_if.red   = r;
    pix_if.green = g;
    pix_if.blue  = b;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    pix_if.valid = 1'b0;
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_frame(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                           logic [CFG_DATA_W-1:0] thr);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_EDGE_THRESHOLD, thr);
  endtask

  task automatic push_drains(int n);
    repeat (n) send_req(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic random_frame(int w, int h);
    int style;
    logic [7:0] base, v;
    style = $urandom_range(0, 3);
    base  = 8'($urandom);
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 15) == 0) push_drains(1);
      case (style)
        0: send_req(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
        1: begin
          v = base + 8'($urandom_range(0, 6)) - 8'd3;
          send_req(1'b0, v, v, v);
        end
        2: begin
          v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          send_req(1'b0, v, v, v);
        end
        default: send_req(1'b0, 8'($urandom_range(200, 255)), 8'($urandom_range(0, 40)),
                          8'($urandom));
      endcase
      random_sent++;
    end
    if ($urandom_range(0, 5) == 0) push_drains($urandom_range(0, w));
    else push_drains(2 * w + 4 + $urandom_range(0, 3));
  endtask

  function automatic int eff(int v, int hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  initial begin
    int w, h, wr, hr, nfr;
    logic [CFG_DATA_W-1:0] thr;
    cycles = 0; burst_left = 0; stall_left = 0; stall_mode = 0; random_sent = 0;
    rst = 1'b1;
    pix_if.valid = 1'b0; pix_if.drain = 1'b0;
    pix_if.red = '0; pix_if.green = '0; pix_if.blue = '0;
    cfg_if.valid = 1'b0; cfg_if.index = '0; cfg_if.data = '0;
    res_if.ready = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset sizes: enough pixels for the first results of the top row
    for (int i = 0; i < 2 * 481 + 40; i++)
      send_req(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
    wait_idle();

    // 3x3, upper data bits ignored by size registers
    set_frame(12'hC03, 12'h403, 12'd0);
    for (int i = 0; i < 9; i++) send_req(1'b0, i == 4 ? 8'hFF : 8'h00, i == 4 ? 8'hFF : 8'h00,
                                         i == 4 ? 8'hFF : 8'h00);
    push_drains(10);
    for (int i = 0; i < 9; i++) send_req(1'b0, i == 4 ? 8'h00 : 8'hFF, i == 4 ? 8'h00 : 8'hFF,
                                         i == 4 ? 8'h00 : 8'hFF);
    push_drains(10);
    wait_idle();
    write_reg(REG_EDGE_THRESHOLD, 12'd4080);
    write_reg(2'd3, 12'hFFF);
    send_req(1'b0, 8'hFF, 8'h00, 8'h00);
    send_req(1'b0, 8'h00, 8'hFF, 8'h00);
    send_req(1'b0, 8'h00, 8'h00, 8'hFF);
    send_req(1'b0, 8'hFF, 8'hFF, 8'hFE);
    send_req(1'b0, 8'hFF, 8'hFF, 8'hFF);
    send_req(1'b0, 8'h01, 8'h01, 8'h00);
    push_drains(2);
    // new frame while results of the previous one are pending
    for (int i = 0; i < 9; i++) send_req(1'b0, 8'hAA, 8'h55, 8'(i * 29));
    push_drains(12);
    wait_idle();
    write_reg(REG_EDGE_THRESHOLD, 12'hFFF);
    for (int i = 0; i < 9; i++) send_req(1'b0, 8'(i * 31), 8'hFF, 8'hFF);
    push_drains(10);
    wait_idle();

    while (random_sent < 750) begin
      case ($urandom_range(0, 9))
        0: wr = $urandom_range(0, 2);
        1: wr = 1023;
        default: wr = $urandom_range(3, 12);
      endcase
      case ($urandom_range(0, 9))
        0: hr = $urandom_range(0, 2);
        1: hr = 1023;
        default: hr = $urandom_range(3, 10);
      endcase
      w = eff(wr, DEF_MAX_WIDTH);
      h = eff(hr, DEF_MAX_HEIGHT);
      if (w * h > 200) begin
        if (w > h) hr = 3; else wr = 3;
        w = eff(wr, DEF_MAX_WIDTH);
        h = eff(hr, DEF_MAX_HEIGHT);
      end
      case ($urandom_range(0, 5))
        0: thr = 12'd0;
        1: thr = 12'd4080;
        2: thr = 12'hFFF;
        3: thr = 12'($urandom_range(0, 4095));
        default: thr = 12'($urandom_range(0, 600));
      endcase
      set_frame(12'(wr), 12'(hr), thr);
      if ($urandom_range(0, 3) == 0) write_reg(2'd3, 12'($urandom));
      nfr = $urandom_range(1, 3);
      repeat (nfr) random_frame(w, h);
      wait_idle();
    end

    // largest sizes
    set_frame(12'd1023, 12'd3, 12'd300);
    random_frame(512, 3);
    wait_idle();
    set_frame(12'd3, 12'd512, 12'd50);
    random_frame(3, 512);
    wait_idle();

    repeat (10) @(posedge clk);
    if (fails == 0) begin
      $display("tb_log_edge_filter_stream passed");
    end else begin
      $display("tb_log_edge_filter_stream failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/lef_pkg.sv
rtl/lef_pixel_if.sv
rtl/lef_result_if.sv
rtl/lef_cfg_if.sv
rtl/lef_line_store.sv
rtl/lef_filter.sv
rtl/log_edge_filter_stream.sv
test/lef_filter_checker.sv
test/tb_log_edge_filter_stream.sv
